### sv/mnd_pkg.sv
`default_nettype none

package mnd_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int NUM_W       = 16;
  localparam int DEN_W       = 16;
  localparam int RATE_W      = 32;
  localparam int FACTOR_W    = 8;
  localparam int COUNT_W     = 5;
  localparam int ENTRY_IDX_W = 4;
  localparam int ENTRY_W     = NUM_W + DEN_W;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int unsigned     RATE_UNIT = 10000;
  localparam longint unsigned RATE_MAX  = (64'd1 << RATE_W) - 64'd1;
  localparam longint unsigned QUOT_MAX  = RATE_MAX / RATE_UNIT;

  localparam int SCALED_W  = $clog2(QUOT_MAX + 1);
  localparam int DIVD_W    = SCALED_W + DEN_W;
  localparam int DIVR_W    = NUM_W + FACTOR_W;
  localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

  // x / 10000 = ((x >> 4) * ceil(2^38 / 625)) >> 38 for any 32-bit x
  localparam int                 RATE_UNIT_SHIFT = 4;
  localparam int                 RECIP_SHIFT     = 38;
  localparam int                 RECIP_W         = 29;
  localparam logic [RECIP_W-1:0] RATE_RECIP      = 29'd439804652;
  localparam int                 SCALE_PROD_W    = RECIP_SHIFT + SCALED_W;

  localparam logic [RATE_W-1:0]      SRC_FREQ_RESET    = 32'd24000000;
  localparam logic [FACTOR_W-1:0]    RATE_FACTOR_RESET = 8'd1;
  localparam logic [COUNT_W-1:0]     ENTRIES_RESET     = '0;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SRC_FREQ       = 2'd0,
    CFG_RATE_FACTOR    = 2'd1,
    CFG_ENTRIES_IN_USE = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic             rescale;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } pair_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [RATE_W-1:0] rate;
  } pair_rsp_t;

endpackage

`default_nettype wire

### sv/mnd_channels.sv
`default_nettype none

interface mnd_req_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic [mnd_pkg::ENTRY_IDX_W-1:0]     entry_index;
  logic [mnd_pkg::NUM_W-1:0]           entry_num;
  logic [mnd_pkg::DEN_W-1:0]           entry_den;
  logic [mnd_pkg::RATE_W-1:0]          desired_rate;
  logic                                apply;

  modport source (
    output valid, func, entry_index, entry_num, entry_den, desired_rate, apply,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, entry_num, entry_den, desired_rate, apply,
    output ready
  );
endinterface

interface mnd_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [mnd_pkg::RATE_W-1:0]  rounded_rate;
  logic [mnd_pkg::NUM_W-1:0]   programmed_num;
  logic [mnd_pkg::DEN_W-1:0]   programmed_den;
  logic [mnd_pkg::RATE_W-1:0]  current_rate;

  modport source (
    output valid, rounded_rate, programmed_num, programmed_den, current_rate,
    input  ready
  );
  modport sink (
    input  valid, rounded_rate, programmed_num, programmed_den, current_rate,
    output ready
  );
endinterface

`default_nettype wire

### sv/mnd_table_ram.sv
`default_nettype none

module mnd_table_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/mnd_divider.sv
`default_nettype none

module mnd_divider (
  input  logic              clk,
  input  logic              rst,
  input  mnd_pkg::div_req_t req,
  output mnd_pkg::div_rsp_t rsp
);
  import mnd_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIVR_W-1:0]    rem;
  logic [DIVR_W-1:0]    divisor;
  logic [DIVD_W-1:0]    quo;
  logic [DIVR_W:0]      trial;
  logic [DIVR_W:0]      diff;
  logic                 fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem, quo[DIVD_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        rem <= fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
        quo <= {quo[DIVD_W-2:0], fits};
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy    <= 1'b1;
        cnt     <= DIV_CNT_W'(DIVD_W);
        rem     <= '0;
        quo     <= req.dividend;
        divisor <= req.divisor;
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

### sv/mnd_pair_rate.sv
`default_nettype none

module mnd_pair_rate (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [mnd_pkg::RATE_W-1:0]      src_freq,
  input  logic [mnd_pkg::FACTOR_W-1:0]    rate_factor,
  input  mnd_pkg::pair_req_t              req,
  output mnd_pkg::pair_rsp_t              rsp
);
  import mnd_pkg::*;

  typedef enum logic [2:0] {
    P_IDLE,
    P_SCALE,
    P_MUL,
    P_DIV_GO,
    P_DIV_WAIT,
    P_FIN
  } pstate_t;

  pstate_t                 state;
  logic                    scaled_ok;
  logic [SCALED_W-1:0]     scaled;
  logic [NUM_W-1:0]        num_q;
  logic [DEN_W-1:0]        den_q;
  logic [DIVD_W-1:0]       prod;
  logic [DIVR_W-1:0]       divr;
  logic [RATE_W-1:0]       rate;
  logic [SCALE_PROD_W-1:0] scale_prod;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  mnd_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // source frequency in units of 10 kHz by reciprocal multiplication
  assign scale_prod = SCALE_PROD_W'(src_freq[RATE_W-1:RATE_UNIT_SHIFT]) *
                      SCALE_PROD_W'(RATE_RECIP);

  always_comb begin
    div_req.start    = (state == P_DIV_GO);
    div_req.dividend = prod;
    div_req.divisor  = divr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= P_IDLE;
      scaled_ok <= 1'b0;
    end else begin
      unique case (state)
        P_IDLE: begin
          if (req.start) begin
            num_q <= req.num;
            den_q <= req.den;
            state <= scaled_ok ? P_MUL : P_SCALE;
          end
        end
        P_SCALE: begin
          scaled    <= scale_prod[RECIP_SHIFT +: SCALED_W];
          scaled_ok <= 1'b1;
          state     <= P_MUL;
        end
        P_MUL: begin
          if (num_q == '0 || den_q == '0 || rate_factor == '0) begin
            rate  <= '0;
            state <= P_FIN;
          end else begin
            prod  <= DIVD_W'(scaled) * DIVD_W'(den_q);
            divr  <= DIVR_W'(num_q) * DIVR_W'(rate_factor);
            state <= P_DIV_GO;
          end
        end
        P_DIV_GO: begin
          state <= P_DIV_WAIT;
        end
        P_DIV_WAIT: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient > DIVD_W'(QUOT_MAX)) begin
              rate <= RATE_W'(RATE_MAX);
            end else begin
              rate <= div_rsp.quotient[RATE_W-1:0] * RATE_W'(RATE_UNIT);
            end
            state <= P_FIN;
          end
        end
        P_FIN: begin
          state <= P_IDLE;
        end
        default: begin
          state <= P_IDLE;
        end
      endcase
      // parent changed: recompute scaled parent on next use
      if (req.rescale) begin
        scaled_ok <= 1'b0;
      end
    end
  end

  assign rsp.busy = (state != P_IDLE);
  assign rsp.done = (state == P_FIN);
  assign rsp.rate = rate;

endmodule

`default_nettype wire

### sv/mn_divider_rate_select.sv
// Load transaction: the next transaction can be accepted the cycle after.
// Rate request: one rate evaluation per table entry walked plus one for the rate of the held
// pair, plus a scaling step once after reset and after each source frequency write.
// The walk is bounded by the radix-2 divider, shared by every rate evaluation.
// One transaction is in work at a time; a finished result waits in the output register.
// Reset: config registers to defaults, held pair zero; table undefined until loaded.
`default_nettype none

module mn_divider_rate_select (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mnd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mnd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  mnd_req_if.sink                            request,
  mnd_rsp_if.source                          result
);
  import mnd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_WAIT,
    S_HELD,
    S_HELD_WAIT,
    S_OUT
  } state_t;

  state_t              state;
  logic [RATE_W-1:0]   src_freq;
  logic [FACTOR_W-1:0] rate_factor;
  logic [COUNT_W-1:0]  entries_in_use;

  logic [COUNT_W-1:0]  count;
  logic [IDX_W-1:0]    idx;
  logic [RATE_W-1:0]   drate;
  logic                apply_q;
  logic [RATE_W-1:0]   rate_q;
  logic [RATE_W-1:0]   result_q;
  logic [NUM_W-1:0]    cur_num;
  logic [DEN_W-1:0]    cur_den;
  logic [NUM_W-1:0]    last_num;
  logic [DEN_W-1:0]    last_den;
  logic [NUM_W-1:0]    held_num;
  logic [DEN_W-1:0]    held_den;
  logic [RATE_W-1:0]   current_q;

  logic                accept;
  logic                load_ok;
  logic [COUNT_W-1:0]  count_next;
  logic [ENTRY_W-1:0]  rd_word;
  logic [NUM_W-1:0]    rd_num;
  logic [DEN_W-1:0]    rd_den;
  logic                last_entry;
  logic                nearer_up;
  pair_req_t           pair_req;
  pair_rsp_t           pair_rsp;

  assign accept  = request.valid && request.ready;
  assign load_ok = (32'(request.entry_index) < TABLE_DEPTH);
  assign count_next = (entries_in_use > COUNT_W'(TABLE_DEPTH)) ?
                      COUNT_W'(TABLE_DEPTH) : entries_in_use;
  assign rd_num = rd_word[ENTRY_W-1:DEN_W];
  assign rd_den = rd_word[DEN_W-1:0];
  assign last_entry = ((COUNT_W'(idx) + COUNT_W'(1)) == count);
  assign nearer_up  = ((drate - rate_q) > (pair_rsp.rate - drate));

  mnd_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_table (
    .clk   (clk),
    .we    (accept && request.func == FUNC_LOAD && load_ok),
    .waddr (request.entry_index[IDX_W-1:0]),
    .wdata ({request.entry_num, request.entry_den}),
    .raddr (idx),
    .rdata (rd_word)
  );

  always_comb begin
    pair_req.rescale = cfg_we && (cfg_index == CFG_SRC_FREQ);
    pair_req.start   = (state == S_EVAL) || (state == S_HELD);
    pair_req.num     = (state == S_EVAL) ? rd_num : held_num;
    pair_req.den     = (state == S_EVAL) ? rd_den : held_den;
  end

  mnd_pair_rate u_pair (
    .clk         (clk),
    .rst         (rst),
    .src_freq    (src_freq),
    .rate_factor (rate_factor),
    .req         (pair_req),
    .rsp         (pair_rsp)
  );

  assign request.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_freq       <= SRC_FREQ_RESET;
      rate_factor    <= RATE_FACTOR_RESET;
      entries_in_use <= ENTRIES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_FREQ:       src_freq       <= cfg_wdata[RATE_W-1:0];
        CFG_RATE_FACTOR:    rate_factor    <= cfg_wdata[FACTOR_W-1:0];
        CFG_ENTRIES_IN_USE: entries_in_use <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      held_num     <= '0;
      held_den     <= '0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_OUT) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && request.func == FUNC_REQUEST) begin
            drate   <= request.desired_rate;
            apply_q <= request.apply;
            count   <= count_next;
            idx     <= '0;
            rate_q  <= '0;
            if (count_next == '0) begin
              result_q <= '0;
              state    <= S_HELD;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          last_num <= cur_num;
          last_den <= cur_den;
          cur_num  <= rd_num;
          cur_den  <= rd_den;
          state    <= S_WAIT;
        end
        S_WAIT: begin
          if (pair_rsp.done) begin
            if (pair_rsp.rate > drate) begin
              if (idx == '0) begin
                result_q <= pair_rsp.rate;
                if (apply_q) begin
                  held_num <= cur_num;
                  held_den <= cur_den;
                end
              end else begin
                result_q <= nearer_up ? pair_rsp.rate : rate_q;
                if (apply_q) begin
                  held_num <= last_num;
                  held_den <= last_den;
                end
              end
              state <= S_HELD;
            end else if (last_entry) begin
              result_q <= pair_rsp.rate;
              if (apply_q) begin
                held_num <= cur_num;
                held_den <= cur_den;
              end
              state <= S_HELD;
            end else begin
              rate_q <= pair_rsp.rate;
              idx    <= idx + IDX_W'(1);
              state  <= S_READ;
            end
          end
        end
        S_HELD: begin
          state <= S_HELD_WAIT;
        end
        S_HELD_WAIT: begin
          if (pair_rsp.done) begin
            current_q <= pair_rsp.rate;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!result.valid || result.ready) begin
            result.valid          <= 1'b1;
            result.rounded_rate   <= result_q;
            result.programmed_num <= held_num;
            result.programmed_den <= held_den;
            result.current_rate   <= current_q;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_pair_start_idle: assert property (@(posedge clk) disable iff (rst)
    pair_req.start |-> !pair_rsp.busy)
    else $error("rate unit started while busy");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> (COUNT_W'(idx) < count))
    else $error("table walk beyond entries in use");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == S_OUT)
    else $error("result raised outside output state");

  a_held_on_apply: assert property (@(posedge clk) disable iff (rst)
    !$stable(held_num) |-> ($past(state) == S_WAIT && $past(apply_q)))
    else $error("held numerator changed without apply");

endmodule

`default_nettype wire

### tb/sv/tb_mn_divider_rate_select.sv
`default_nettype none

module tb_mn_divider_rate_select;
  import mnd_pkg::*;

  localparam int unsigned     WATCHDOG_LIMIT  = 20000;
  localparam int unsigned     RSP_HOLD_CYCLES = 3000;
  localparam int unsigned     SETTLE_CYCLES   = 16;
  localparam int unsigned     TAIL_CYCLES     = 800;
  localparam int unsigned     RANDOM_ITEMS    = 930;
  localparam longint unsigned RATE_LIMIT      = 64'hFFFF_FFFF;

  localparam logic [NUM_W-1:0] DIR_NUM [TABLE_DEPTH] = '{
    16'd0, 16'd9, 16'd65535, 16'd2400, 16'd1200, 16'd800, 16'd100, 16'd10,
    16'd2, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd3
  };
  localparam logic [DEN_W-1:0] DIR_DEN [TABLE_DEPTH] = '{
    16'd7, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1,
    16'd1, 16'd1, 16'd10, 16'd100, 16'd178, 16'd179, 16'd65535, 16'd65535
  };

  typedef struct packed {
    logic [RATE_W-1:0] rounded;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic [RATE_W-1:0] current;
  } pick_t;

  class rate_selector_check;
    logic [RATE_W-1:0]   parent;
    logic [FACTOR_W-1:0] factor;
    logic [COUNT_W-1:0]  count;
    logic [NUM_W-1:0]    slot_num [TABLE_DEPTH];
    logic [DEN_W-1:0]    slot_den [TABLE_DEPTH];
    logic [NUM_W-1:0]    held_num;
    logic [DEN_W-1:0]    held_den;
    pick_t               pending_picks [$];
    int unsigned         errors;

    function new();
      parent   = 32'd24_000_000;
      factor   = 8'd1;
      count    = '0;
      held_num = '0;
      held_den = '0;
      errors   = 0;
      foreach (slot_num[k]) begin
        slot_num[k] = '0;
        slot_den[k] = '0;
      end
    endfunction

    function void set_reg(cfg_index_t ix, logic [CFG_DATA_W-1:0] value);
      case (ix)
        CFG_SRC_FREQ:       parent = value[RATE_W-1:0];
        CFG_RATE_FACTOR:    factor = value[FACTOR_W-1:0];
        CFG_ENTRIES_IN_USE: count  = value[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [RATE_W-1:0] divided_rate(logic [NUM_W-1:0] n, logic [DEN_W-1:0] d);
      longint unsigned scaled, divisor, quot;
      scaled  = parent;
      divisor = n;
      divisor = divisor * factor;
      if (n == '0 || d == '0 || divisor == 0)
        return '0;
      scaled = scaled / RATE_UNIT;
      quot   = scaled * d / divisor;
      if (quot > RATE_LIMIT / RATE_UNIT)
        return '1;
      return RATE_W'(quot * RATE_UNIT);
    endfunction

    function void note_transaction(logic func, logic [ENTRY_IDX_W-1:0] idx,
                                   logic [NUM_W-1:0] num, logic [DEN_W-1:0] den,
                                   logic [RATE_W-1:0] want, logic apply);
      int unsigned       cnt, i, sel;
      logic [RATE_W-1:0] rate, prev;
      pick_t             p;
      if (func == FUNC_LOAD) begin
        slot_num[idx] = num;
        slot_den[idx] = den;
        return;
      end
      cnt  = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
      rate = '0;
      prev = '0;
      for (i = 0; i < cnt; i++) begin
        prev = rate;
        rate = divided_rate(slot_num[i], slot_den[i]);
        if (rate > want)
          break;
      end
      if (i == 0 || i == cnt)
        p.rounded = rate;
      else if ((want - prev) > (rate - want))
        p.rounded = rate;
      else
        p.rounded = prev;
      if (apply && cnt > 0) begin
        sel      = (i > 0) ? i - 1 : 0;
        held_num = slot_num[sel];
        held_den = slot_den[sel];
      end
      p.num     = held_num;
      p.den     = held_den;
      p.current = divided_rate(held_num, held_den);
      pending_picks.push_back(p);
    endfunction

    task report(string what, logic [RATE_W-1:0] got, logic [RATE_W-1:0] want);
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
      errors++;
    endtask

    task check_pick(pick_t got);
      pick_t want;
      if (pending_picks.size() == 0) begin
        report("unexpected result, rounded_rate", got.rounded, '0);
        return;
      end
      want = pending_picks.pop_front();
      if (got.rounded !== want.rounded)
        report("rounded_rate", got.rounded, want.rounded);
      if (got.num !== want.num)
        report("programmed_num", RATE_W'(got.num), RATE_W'(want.num));
      if (got.den !== want.den)
        report("programmed_den", RATE_W'(got.den), RATE_W'(want.den));
      if (got.current !== want.current)
        report("current_rate", got.current, want.current);
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  mnd_req_if req_if ();
  mnd_rsp_if rsp_if ();

  mn_divider_rate_select u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .request   (req_if),
    .result    (rsp_if)
  );

  rate_selector_check sb = new();

  logic [NUM_W-1:0] loaded_num [TABLE_DEPTH];
  logic [DEN_W-1:0] loaded_den [TABLE_DEPTH];
  bit               gaps_on      = 1'b1;
  bit               stalls_on    = 1'b1;
  bit               hold_results = 1'b0;
  int unsigned      items_sent   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // transaction monitor
  always @(posedge clk) begin
    if (!rst && req_if.valid && req_if.ready)
      sb.note_transaction(req_if.func, req_if.entry_index, req_if.entry_num,
                          req_if.entry_den, req_if.desired_rate, req_if.apply);
    if (!rst && rsp_if.valid && rsp_if.ready)
      sb.check_pick(pick_t'{rsp_if.rounded_rate, rsp_if.programmed_num,
                            rsp_if.programmed_den, rsp_if.current_rate});
  end

  // result side
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        rsp_if.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= !(stalls_on && $urandom_range(0, 99) < 25);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("** mn_divider_rate_select: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_item(logic func, logic [ENTRY_IDX_W-1:0] idx, logic [NUM_W-1:0] num,
                           logic [DEN_W-1:0] den, logic [RATE_W-1:0] want, logic apply);
    if (gaps_on)
      while ($urandom_range(0, 99) < 25) begin
        req_if.valid <= 1'b0;
        @(posedge clk);
      end
    req_if.valid        <= 1'b1;
    req_if.func         <= func;
    req_if.entry_index  <= idx;
    req_if.entry_num    <= num;
    req_if.entry_den    <= den;
    req_if.desired_rate <= want;
    req_if.apply        <= apply;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_load(logic [ENTRY_IDX_W-1:0] idx, logic [NUM_W-1:0] num,
                           logic [DEN_W-1:0] den);
    loaded_num[idx] = num;
    loaded_den[idx] = den;
    send_item(FUNC_LOAD, idx, num, den, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_request(logic [RATE_W-1:0] want, logic apply);
    send_item(FUNC_REQUEST, ENTRY_IDX_W'($urandom), NUM_W'($urandom), DEN_W'($urandom),
              want, apply);
  endtask

  task automatic drain(int unsigned settle);
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_picks.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t ix, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= ix;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(ix, value);
    @(posedge clk);
  endtask

  task automatic load_sorted_table();
    int unsigned dens [$];
    int unsigned nums [$];
    int unsigned dbits, nbits;
    dbits = $urandom_range(1, 16);
    nbits = $urandom_range(1, 16);
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      dens.push_back($urandom_range(1, (1 << dbits) - 1));
      nums.push_back($urandom_range(1, (1 << nbits) - 1));
    end
    dens.sort();
    nums.rsort();
    for (int k = 0; k < TABLE_DEPTH; k++)
      send_load(ENTRY_IDX_W'(k), NUM_W'(nums[k]), DEN_W'(dens[k]));
  endtask

  function automatic logic [RATE_W-1:0] pick_target();
    int unsigned     cnt, k;
    longint unsigned lo, hi;
    cnt = (sb.count > TABLE_DEPTH) ? TABLE_DEPTH : sb.count;
    if (cnt == 0)
      return $urandom;
    k  = $urandom_range(0, cnt - 1);
    lo = sb.divided_rate(loaded_num[k], loaded_den[k]);
    hi = (k + 1 < cnt) ? sb.divided_rate(loaded_num[k + 1], loaded_den[k + 1]) : lo;
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      2, 3:    return RATE_W'(lo);
      4, 5:    return RATE_W'(lo + $urandom_range(0, 6) - 3);
      6:       return RATE_W'((lo + hi + $urandom_range(0, 1)) / 2);
      default: return RATE_W'(lo + $urandom_range(0, 100000));
    endcase
  endfunction

  task automatic pick_settings();
    logic [CFG_DATA_W-1:0] parent, factor, count;
    case ($urandom_range(0, 7))
      0:       parent = 32'd0;
      1:       parent = 32'hFFFF_FFFF;
      2:       parent = 32'd24_000_000;
      3:       parent = 32'd9999;
      4:       parent = $urandom;
      default: parent = $urandom_range(10000, 400_000_000);
    endcase
    case ($urandom_range(0, 9))
      0:       factor = 32'd0;
      1:       factor = 32'd255;
      2, 3:    factor = 32'd1;
      default: factor = $urandom_range(1, 255);
    endcase
    case ($urandom_range(0, 9))
      0:       count = 32'd0;
      1, 2:    count = 32'd16;
      3:       count = $urandom_range(17, 31);
      default: count = $urandom_range(1, 16);
    endcase
    write_reg(CFG_SRC_FREQ, parent);
    write_reg(CFG_RATE_FACTOR, factor);
    write_reg(CFG_ENTRIES_IN_USE, count);
  endtask

  initial begin
    int unsigned phase, n;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_SRC_FREQ;
    cfg_wdata           <= '0;
    req_if.valid        <= 1'b0;
    req_if.func         <= FUNC_LOAD;
    req_if.entry_index  <= '0;
    req_if.entry_num    <= '0;
    req_if.entry_den    <= '0;
    req_if.desired_rate <= '0;
    req_if.apply        <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, then the directed table at the default parent rate and at extreme settings
    send_request(32'd0, 1'b1);
    send_request(32'hFFFF_FFFF, 1'b0);
    for (int k = 0; k < TABLE_DEPTH; k++)
      send_load(ENTRY_IDX_W'(k), DIR_NUM[k], DIR_DEN[k]);
    drain(SETTLE_CYCLES);
    write_reg(CFG_ENTRIES_IN_USE, 32'd16);
    send_request(32'd0, 1'b1);
    send_request(32'd15000, 1'b0);
    send_request(32'd15001, 1'b1);
    send_request(32'd4_272_000_000, 1'b1);
    send_request(32'hFFFF_FFFF, 1'b1);
    drain(SETTLE_CYCLES);
    write_reg(CFG_ENTRIES_IN_USE, 32'd31);
    write_reg(CFG_RATE_FACTOR, 32'd0);
    send_request(32'd20000, 1'b1);
    drain(SETTLE_CYCLES);
    write_reg(CFG_RATE_FACTOR, 32'd255);
    write_reg(CFG_SRC_FREQ, 32'hFFFF_FFFF);
    write_reg(CFG_ENTRIES_IN_USE, 32'd1);
    send_request(32'd1, 1'b1);

    items_sent = 0;
    phase      = 0;
    while (items_sent < RANDOM_ITEMS) begin
      drain(SETTLE_CYCLES);
      gaps_on   = (phase != 3);
      stalls_on = (phase != 3);
      pick_settings();
      if (phase == 1)
        hold_results = 1'b1;
      if (phase == 0 || $urandom_range(0, 99) < 70)
        load_sorted_table();
      n = (phase == 3) ? 150 : $urandom_range(40, 90);
      for (int k = 0; k < n; k++) begin
        if (phase == 2 && k == n / 2)
          drain(0);
        if ($urandom_range(0, 99) < 10)
          send_load(ENTRY_IDX_W'($urandom), NUM_W'($urandom), DEN_W'($urandom));
        else
          send_request(pick_target(), 1'($urandom_range(0, 1)));
      end
      phase++;
    end

    drain(TAIL_CYCLES);
    if (sb.errors == 0)
      $display("** mn_divider_rate_select: PASSED **");
    else
      $display("** mn_divider_rate_select: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
sv/mnd_pkg.sv
sv/mnd_channels.sv
sv/mnd_table_ram.sv
sv/mnd_divider.sv
sv/mnd_pair_rate.sv
sv/mn_divider_rate_select.sv
tb/sv/tb_mn_divider_rate_select.sv
